/* rtl/splg_pkg.sv */
// Shared types, constants and arithmetic helpers for the stereo pan-law gain unit.
// No dependencies; imported by every module of the block.
package splg_pkg;

    typedef enum logic [1:0] {
        LAW_SINE    = 2'd0,
        LAW_SQRT    = 2'd1,
        LAW_LINEAR  = 2'd2,
        LAW_ROTATED = 2'd3
    } t_pan_law;

    localparam int GAIN_BITS   = 16;
    localparam int LANE_STAGES = 6;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'd32768;

    // Q30 value, unsigned; wide enough for 1.0 and for every polynomial term
    typedef logic [30:0] t_q30;

    // Magnitudes of the odd Taylor terms of sin(x*pi/2), Q30
    localparam t_q30 C1 = 31'd1686629713;
    localparam t_q30 C3 = 31'd693598670;
    localparam t_q30 C5 = 31'd85569306;
    localparam t_q30 C7 = 31'd5026996;
    localparam t_q30 C9 = 31'd172272;

    localparam logic [62:0] Q30_HALF = 63'd1 << 29;

    // Digit-by-digit square root: 36-bit radicand, 18-bit root
    localparam int SQ_RAD_BITS  = 36;
    localparam int SQ_REM_BITS  = 20;
    localparam int SQ_ROOT_BITS = 18;
    localparam int SQ_STEPS     = 3;

    typedef struct packed {
        logic [SQ_REM_BITS-1:0]  rem;
        logic [SQ_ROOT_BITS-1:0] root;
    } t_sqrt_state;

    // a*b/2^30 rounded half up; callers keep the result below 2^31
    function automatic t_q30 mul_q30(t_q30 a, t_q30 b);
        logic [62:0] p;
        p = {32'b0, a} * {32'b0, b} + Q30_HALF;
        return p[60:30];
    endfunction

    // One root bit: bring down two radicand bits, try (root<<2)|1
    function automatic t_sqrt_state sqrt_step(t_sqrt_state st, logic [1:0] pair);
        logic [SQ_REM_BITS-1:0] rem_sh;
        logic [SQ_REM_BITS-1:0] trial;
        t_sqrt_state            nx;
        rem_sh = {st.rem[SQ_REM_BITS-3:0], pair};
        trial  = {st.root, 2'b01};
        if (rem_sh >= trial) begin
            nx.rem  = rem_sh - trial;
            nx.root = {st.root[SQ_ROOT_BITS-2:0], 1'b1};
        end else begin
            nx.rem  = rem_sh;
            nx.root = {st.root[SQ_ROOT_BITS-2:0], 1'b0};
        end
        return nx;
    endfunction

endpackage

/* rtl/splg_sine_lane.sv */
// Six-stage pipelined sin(x*pi/2) polynomial, one Q30 multiply per stage.
// Depends on splg_pkg (coefficients, mul_q30).
module splg_sine_lane #(
    parameter int PAN_FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_ce,
    input  logic [PAN_FRAC_BITS:0] i_x,
    output splg_pkg::t_q30         o_s
);
    import splg_pkg::*;

    t_q30 xq;
    t_q30 r_xq [0:4];
    t_q30 r_x2 [0:3];
    t_q30 r_m1;
    t_q30 r_m2;
    t_q30 r_m3;
    t_q30 r_m4;
    t_q30 r_s;

    assign xq = {i_x, {(30 - PAN_FRAC_BITS){1'b0}}};

    // Horner terms alternate in sign; each stage keeps the magnitude
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_xq[0] <= xq;
            r_x2[0] <= mul_q30(xq, xq);
            for (int k = 1; k < 5; k++) begin
                r_xq[k] <= r_xq[k-1];
            end
            for (int k = 1; k < 4; k++) begin
                r_x2[k] <= r_x2[k-1];
            end
            r_m1 <= C7 - mul_q30(C9, r_x2[0]);
            r_m2 <= C5 - mul_q30(r_m1, r_x2[1]);
            r_m3 <= C3 - mul_q30(r_m2, r_x2[2]);
            r_m4 <= C1 - mul_q30(r_m3, r_x2[3]);
            r_s  <= mul_q30(r_m4, r_xq[4]);
        end
    end

    assign o_s = r_s;

endmodule

/* rtl/splg_sqrt_lane.sv */
// Six-stage pipelined integer square root of x*2^(32-PAN_FRAC_BITS),
// three root bits per stage. Depends on splg_pkg (t_sqrt_state, sqrt_step).
module splg_sqrt_lane #(
    parameter int PAN_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_ce,
    input  logic [PAN_FRAC_BITS:0]              i_x,
    output logic [splg_pkg::SQ_ROOT_BITS-1:0]   o_root
);
    import splg_pkg::*;

    t_sqrt_state            st_in  [0:LANE_STAGES-1];
    logic [SQ_RAD_BITS-1:0] rad_in [0:LANE_STAGES-1];
    t_sqrt_state            n_st   [0:LANE_STAGES-1];
    logic [SQ_RAD_BITS-1:0] n_rad  [0:LANE_STAGES-1];
    t_sqrt_state            r_st   [0:LANE_STAGES-1];
    logic [SQ_RAD_BITS-1:0] r_rad  [0:LANE_STAGES-1];

    for (genvar g = 0; g < LANE_STAGES; g++) begin : g_link
        if (g == 0) begin : g_first
            assign st_in[g]  = '0;
            assign rad_in[g] = {3'b000, i_x, {(32 - PAN_FRAC_BITS){1'b0}}};
        end else begin : g_rest
            assign st_in[g]  = r_st[g-1];
            assign rad_in[g] = r_rad[g-1];
        end
    end

    always_comb begin
        for (int k = 0; k < LANE_STAGES; k++) begin
            n_st[k] = st_in[k];
            for (int j = 0; j < SQ_STEPS; j++) begin
                n_st[k] = sqrt_step(n_st[k],
                                    rad_in[k][SQ_RAD_BITS-1-2*j -: 2]);
            end
            n_rad[k] = rad_in[k] << (2 * SQ_STEPS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < LANE_STAGES; k++) begin
                r_st[k]  <= n_st[k];
                r_rad[k] <= n_rad[k];
            end
        end
    end

    assign o_root = r_st[LANE_STAGES-1].root;

endmodule

/* rtl/stereo_pan_law_gain_unit.sv */
// Top level of the stereo pan-law gain unit: mono sample plus pan in, left/right out.
// Depends on splg_pkg, splg_sine_lane and splg_sqrt_lane.
//
// One item is accepted per clock while o_in_ready is high. The pipeline has ten
// register stages: the six-stage sine polynomial (one Q30 multiply per stage),
// matched by the square-root lanes at three root bits per stage, plus input
// clamp, gain select, output multiply and round/saturate stages. Law 3 (rotated)
// gives the same bits as law 0 and shares its lanes. A skid register behind the
// last stage catches a result that is not taken so the pipeline can advance;
// o_in_ready drops only while the skid register is occupied. pan_law is written
// through i_cfg_wr_en/i_cfg_wr_data; the user must write it only while the block
// is idle, and the block itself does not enforce this.
module stereo_pan_law_gain_unit #(
    parameter int SAMPLE_BITS   = 24,
    parameter int PAN_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [1:0]                    i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic [PAN_FRAC_BITS:0]        i_pan_pos,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out
);
    import splg_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int XW     = PAN_FRAC_BITS + 1;
    localparam int DEPTH  = LANE_STAGES + 4;

    localparam logic [XW-1:0]    PAN_ONE    = XW'(1) << PAN_FRAC_BITS;
    localparam logic [XW+15:0]   LIN_HALF   = (XW + 16)'(1) << (PAN_FRAC_BITS - 1);
    localparam logic [SB+16:0]   ROUND_HALF = (SB + 17)'(16384);
    localparam logic [SB+1:0]    POS_LIM    = {3'b000, {(SB - 1){1'b1}}};
    localparam logic [SB+1:0]    NEG_LIM    = {2'b00, 1'b1, {(SB - 1){1'b0}}};

    function automatic logic [GAIN_BITS-1:0] lin_gain(logic [XW-1:0] x);
        logic [XW+15:0] s;
        s = {1'b0, x, 15'b0} + LIN_HALF;
        return GAIN_BITS'(s >> PAN_FRAC_BITS);
    endfunction

    function automatic logic [GAIN_BITS-1:0] sine_gain(t_q30 s);
        logic [31:0] sum;
        sum = {1'b0, s} + 32'd16384;
        return (sum[31:15] > {1'b0, GAIN_ONE}) ? GAIN_ONE : sum[30:15];
    endfunction

    function automatic logic [GAIN_BITS-1:0] sqrt_gain(logic [SQ_ROOT_BITS-1:0] q);
        logic [SQ_ROOT_BITS:0] sum;
        sum = {1'b0, q} + 1'b1;
        return sum[GAIN_BITS:1];
    endfunction

    // Round half away from zero by 2^15, then clamp to the sample range
    function automatic logic [SB-1:0] round_sat(logic [SB+15:0] prod, logic neg);
        logic [SB+16:0] rs;
        logic [SB+1:0]  r;
        logic [SB-1:0]  res;
        rs = {1'b0, prod} + ROUND_HALF;
        r  = rs[SB+16:15];
        if (!neg) begin
            res = (r > POS_LIM) ? POS_LIM[SB-1:0] : r[SB-1:0];
        end else begin
            res = (r > NEG_LIM) ? NEG_LIM[SB-1:0] : (~r[SB-1:0] + 1'b1);
        end
        return res;
    endfunction

    t_pan_law r_pan_law;
    logic [DEPTH-1:0] r_v;
    logic ce;

    logic [SB-1:0] raw;
    logic          in_neg;
    logic [SB-1:0] in_mag;
    logic [XW-1:0] in_x;

    // stage 1
    logic [XW-1:0] r_x_r;
    logic [XW-1:0] r_x_l;
    logic [SB-1:0] r_mag;
    logic          r_neg;

    // lane stages
    logic [XW-1:0] r_d_x_r [0:LANE_STAGES-1];
    logic [XW-1:0] r_d_x_l [0:LANE_STAGES-1];
    logic [SB-1:0] r_d_mag [0:LANE_STAGES-1];
    logic          r_d_neg [0:LANE_STAGES-1];

    t_q30                    sin_r;
    t_q30                    sin_l;
    logic [SQ_ROOT_BITS-1:0] sq_r;
    logic [SQ_ROOT_BITS-1:0] sq_l;

    logic [GAIN_BITS-1:0] n_gl;
    logic [GAIN_BITS-1:0] n_gr;

    // gain select, product and output stages
    logic [GAIN_BITS-1:0] r_gl;
    logic [GAIN_BITS-1:0] r_gr;
    logic [SB-1:0]        r_mag8;
    logic                 r_neg8;
    logic [SB+15:0]       r_prod_l;
    logic [SB+15:0]       r_prod_r;
    logic                 r_neg9;
    logic [SB-1:0]        r_left;
    logic [SB-1:0]        r_right;

    logic          r_skid_v;
    logic [SB-1:0] r_skid_left;
    logic [SB-1:0] r_skid_right;

    assign ce         = !r_skid_v;
    assign o_in_ready = ce;

    assign raw    = i_sample_in;
    assign in_neg = raw[SB-1];
    assign in_mag = in_neg ? (~raw + 1'b1) : raw;
    assign in_x   = (i_pan_pos > PAN_ONE) ? PAN_ONE : i_pan_pos;

    splg_sine_lane #(.PAN_FRAC_BITS(PAN_FRAC_BITS)) u_sine_r (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_x   (r_x_r),
        .o_s   (sin_r)
    );

    splg_sine_lane #(.PAN_FRAC_BITS(PAN_FRAC_BITS)) u_sine_l (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_x   (r_x_l),
        .o_s   (sin_l)
    );

    splg_sqrt_lane #(.PAN_FRAC_BITS(PAN_FRAC_BITS)) u_sqrt_r (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_x    (r_x_r),
        .o_root (sq_r)
    );

    splg_sqrt_lane #(.PAN_FRAC_BITS(PAN_FRAC_BITS)) u_sqrt_l (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_x    (r_x_l),
        .o_root (sq_l)
    );

    always_comb begin
        unique case (r_pan_law)
            LAW_SQRT: begin
                n_gl = sqrt_gain(sq_l);
                n_gr = sqrt_gain(sq_r);
            end
            LAW_LINEAR: begin
                n_gl = lin_gain(r_d_x_l[LANE_STAGES-1]);
                n_gr = lin_gain(r_d_x_r[LANE_STAGES-1]);
            end
            LAW_SINE, LAW_ROTATED: begin
                n_gl = sine_gain(sin_l);
                n_gr = sine_gain(sin_r);
            end
            default: begin
                n_gl = sine_gain(sin_l);
                n_gr = sine_gain(sin_r);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_law <= LAW_SINE;
            r_v       <= '0;
            r_skid_v  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_pan_law <= t_pan_law'(i_cfg_wr_data);
            end
            if (ce) begin
                r_v <= {r_v[DEPTH-2:0], i_in_valid};
                if (r_v[DEPTH-1] && !i_out_ready) begin
                    r_skid_v <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_skid_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_x_r <= in_x;
            r_x_l <= PAN_ONE - in_x;
            r_mag <= in_mag;
            r_neg <= in_neg;

            r_d_x_r[0] <= r_x_r;
            r_d_x_l[0] <= r_x_l;
            r_d_mag[0] <= r_mag;
            r_d_neg[0] <= r_neg;
            for (int k = 1; k < LANE_STAGES; k++) begin
                r_d_x_r[k] <= r_d_x_r[k-1];
                r_d_x_l[k] <= r_d_x_l[k-1];
                r_d_mag[k] <= r_d_mag[k-1];
                r_d_neg[k] <= r_d_neg[k-1];
            end

            r_gl   <= n_gl;
            r_gr   <= n_gr;
            r_mag8 <= r_d_mag[LANE_STAGES-1];
            r_neg8 <= r_d_neg[LANE_STAGES-1];

            r_prod_l <= {16'b0, r_mag8} * {{SB{1'b0}}, r_gl};
            r_prod_r <= {16'b0, r_mag8} * {{SB{1'b0}}, r_gr};
            r_neg9   <= r_neg8;

            r_left  <= round_sat(r_prod_l, r_neg9);
            r_right <= round_sat(r_prod_r, r_neg9);

            if (r_v[DEPTH-1] && !i_out_ready) begin
                r_skid_left  <= r_left;
                r_skid_right <= r_right;
            end
        end
    end

    assign o_out_valid = r_skid_v | r_v[DEPTH-1];
    assign o_left_out  = r_skid_v ? r_skid_left : r_left;
    assign o_right_out = r_skid_v ? r_skid_right : r_right;

endmodule

/* tb/stereo_pan_law_gain_unit_tb.sv */
// Self-checking testbench for stereo_pan_law_gain_unit: directed table, then random items.
// Depends on splg_pkg and the RTL of the block; everything is predicted in place.
// Covers all four pan laws, both handshake sides idling and stalling, and pan clamping.
module stereo_pan_law_gain_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import splg_pkg::*;

    localparam int SMP_W    = 24;
    localparam int PAN_W    = 17;
    localparam longint PAN_FULL = 65536;
    localparam longint GAIN_FULL = 32768;
    localparam logic signed [SMP_W-1:0] SMP_MAX = 24'sh7FFFFF;
    localparam logic signed [SMP_W-1:0] SMP_MIN = 24'sh800000;

    // odd Taylor terms of sin(x*pi/2), Q30 magnitudes
    localparam longint SIN_K1 = 1686629713;
    localparam longint SIN_K3 = 693598670;
    localparam longint SIN_K5 = 85569306;
    localparam longint SIN_K7 = 5026996;
    localparam longint SIN_K9 = 172272;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_s;
        logic signed [SMP_W-1:0] right_s;
    } lr_pair_t;

    typedef struct packed {
        t_pan_law                law;
        logic signed [SMP_W-1:0] smp;
        logic [PAN_W-1:0]        pan;
        logic                    known;
        logic signed [SMP_W-1:0] exp_l;
        logic signed [SMP_W-1:0] exp_r;
    } dir_row_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [1:0]              i_cfg_wr_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic signed [SMP_W-1:0] i_sample_in;
    logic [PAN_W-1:0]        i_pan_pos;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b1;
    logic signed [SMP_W-1:0] o_left_out;
    logic signed [SMP_W-1:0] o_right_out;

    lr_pair_t lr_expect_q[$];
    lr_pair_t head;
    t_pan_law cur_law;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       n_items = 0;
    int       n_results = 0;
    int       n_law_writes = 0;
    int       n_fail = 0;

    dir_row_t dir_tab [20] = '{
        '{LAW_SINE,    24'sd0,       17'd0,      1'b1, 24'sd0,         24'sd0},
        '{LAW_SINE,    SMP_MAX,      17'd0,      1'b1, SMP_MAX,        24'sd0},
        '{LAW_SINE,    SMP_MIN,      17'd65536,  1'b1, 24'sd0,         SMP_MIN},
        '{LAW_SINE,    SMP_MAX,      17'd131071, 1'b1, 24'sd0,         SMP_MAX},
        '{LAW_SINE,    SMP_MIN,      17'd32768,  1'b0, 24'sd0,         24'sd0},
        '{LAW_SINE,    24'sd1,       17'd12345,  1'b0, 24'sd0,         24'sd0},
        '{LAW_SQRT,    SMP_MAX,      17'd0,      1'b1, SMP_MAX,        24'sd0},
        '{LAW_SQRT,    SMP_MIN,      17'd65536,  1'b1, 24'sd0,         SMP_MIN},
        '{LAW_SQRT,    24'sd5000000, 17'd16384,  1'b0, 24'sd0,         24'sd0},
        '{LAW_SQRT,    -24'sd1,      17'd65537,  1'b1, 24'sd0,         -24'sd1},
        '{LAW_LINEAR,  SMP_MAX,      17'd32768,  1'b1, 24'sd4194304,   24'sd4194304},
        '{LAW_LINEAR,  SMP_MIN,      17'd32768,  1'b1, -24'sd4194304,  -24'sd4194304},
        '{LAW_LINEAR,  SMP_MAX,      17'd0,      1'b1, SMP_MAX,        24'sd0},
        '{LAW_LINEAR,  24'sd123456,  17'd131071, 1'b1, 24'sd0,         24'sd123456},
        '{LAW_LINEAR,  -24'sd3,      17'd1,      1'b0, 24'sd0,         24'sd0},
        '{LAW_ROTATED, SMP_MAX,      17'd0,      1'b1, SMP_MAX,        24'sd0},
        '{LAW_ROTATED, SMP_MIN,      17'd131071, 1'b1, 24'sd0,         SMP_MIN},
        '{LAW_ROTATED, 24'sd7777777, 17'd40000,  1'b0, 24'sd0,         24'sd0},
        '{LAW_ROTATED, 24'sd0,       17'd65536,  1'b1, 24'sd0,         24'sd0},
        '{LAW_ROTATED, -24'sd4000000, 17'd65535, 1'b0, 24'sd0,         24'sd0}
    };

    stereo_pan_law_gain_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample_in   (i_sample_in),
        .i_pan_pos     (i_pan_pos),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_left_out    (o_left_out),
        .o_right_out   (o_right_out)
    );

    // Q30 product, rounded half up in magnitude, sign kept
    function automatic longint q30_round_mul(longint a, longint b);
        if (a < 0) begin
            return -(((-a) * b + (64'sd1 <<< 29)) >>> 30);
        end
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint sine_gain_q15(longint x);
        longint xq;
        longint x2;
        longint t;
        longint s;
        longint g;
        xq = x <<< 14;
        x2 = q30_round_mul(xq, xq);
        t  = SIN_K9;
        t  = q30_round_mul(t, x2) - SIN_K7;
        t  = q30_round_mul(t, x2) + SIN_K5;
        t  = q30_round_mul(t, x2) - SIN_K3;
        t  = q30_round_mul(t, x2) + SIN_K1;
        s  = q30_round_mul(t, xq);
        if (s < 0) s = 0;
        g = (s + 16384) >>> 15;
        return (g > GAIN_FULL) ? GAIN_FULL : g;
    endfunction

    // exact integer root of x * 2^16, then halved with rounding
    function automatic longint sqrt_gain_q15(longint x);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = longint'(x) << 16;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'((r + 1) >> 1);
    endfunction

    function automatic longint linear_gain_q15(longint x);
        return ((x <<< 15) + 32768) >>> 16;
    endfunction

    function automatic logic signed [SMP_W-1:0] scale_sample(logic signed [SMP_W-1:0] smp,
                                                             longint gain);
        longint s;
        longint mag;
        longint r;
        s   = smp;
        mag = (s < 0) ? -s : s;
        r   = (mag * gain + 16384) >>> 15;
        if (s < 0) r = -r;
        if (r > longint'(SMP_MAX)) r = SMP_MAX;
        if (r < longint'(SMP_MIN)) r = SMP_MIN;
        return r[SMP_W-1:0];
    endfunction

    function automatic lr_pair_t predict_lr(t_pan_law law, logic signed [SMP_W-1:0] smp,
                                            logic [PAN_W-1:0] pan);
        longint   x;
        longint   gl;
        longint   gr;
        lr_pair_t res;
        x = pan;
        if (x > PAN_FULL) x = PAN_FULL;
        case (law)
            LAW_SQRT: begin
                gr = sqrt_gain_q15(x);
                gl = sqrt_gain_q15(PAN_FULL - x);
            end
            LAW_LINEAR: begin
                gr = linear_gain_q15(x);
                gl = linear_gain_q15(PAN_FULL - x);
            end
            default: begin
                // rotated law reduces to the same sine/cosine pair
                gr = sine_gain_q15(x);
                gl = sine_gain_q15(PAN_FULL - x);
            end
        endcase
        res.left_s  = scale_sample(smp, gl);
        res.right_s = scale_sample(smp, gr);
        return res;
    endfunction

    function automatic logic signed [SMP_W-1:0] rand_sample();
        case ($urandom_range(19))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return 24'sd0;
            3: return 24'(int'($urandom_range(8)) - 4);
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [PAN_W-1:0] rand_pan();
        case ($urandom_range(19))
            0: return 17'd0;
            1: return 17'd65536;
            2, 3: return PAN_W'($urandom_range(131071, 65537));
            4: return PAN_W'($urandom_range(3));
            5: return 17'(65536 - $urandom_range(3));
            default: return PAN_W'($urandom_range(65536));
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(input logic signed [SMP_W-1:0] smp, input logic [PAN_W-1:0] pan,
                             input lr_pair_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= smp;
        i_pan_pos   <= pan;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        lr_expect_q.push_back(want);
        n_items++;
        @(negedge i_clk);
    endtask

    // every item yields a result, so an empty queue means the pipeline is empty
    task automatic program_law(input t_pan_law law);
        i_in_valid <= 1'b0;
        while (lr_expect_q.size() != 0) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= law;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_law = law;
        n_law_writes++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lr_expect_q.size() == 0) begin
                $error("unexpected result: left_out %0d right_out %0d", o_left_out, o_right_out);
                n_fail++;
            end else begin
                head = lr_expect_q.pop_front();
                n_results++;
                if (o_left_out !== head.left_s) begin
                    $error("left_out: expected %0d, got %0d", head.left_s, o_left_out);
                    n_fail++;
                end
                if (o_right_out !== head.right_s) begin
                    $error("right_out: expected %0d, got %0d", head.right_s, o_right_out);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        lr_pair_t                want;
        logic signed [SMP_W-1:0] smp;
        logic [PAN_W-1:0]        pan;
        int                      mode;
        int                      waited;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = LAW_SINE;
        i_in_valid    = 1'b0;
        i_sample_in   = '0;
        i_pan_pos     = '0;
        cur_law       = LAW_SINE;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, starting from the reset law
        foreach (dir_tab[i]) begin
            if (dir_tab[i].law != cur_law) program_law(dir_tab[i].law);
            if (dir_tab[i].known) begin
                want.left_s  = dir_tab[i].exp_l;
                want.right_s = dir_tab[i].exp_r;
            end else begin
                want = predict_lr(cur_law, dir_tab[i].smp, dir_tab[i].pan);
            end
            send_item(dir_tab[i].smp, dir_tab[i].pan, want);
        end

        // each law meets each idling mode once
        for (int ph = 0; ph < 16; ph++) begin
            mode = ph % 4;
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            program_law(t_pan_law'((mode + ph / 4) % 4));
            repeat (64) begin
                smp = rand_sample();
                pan = rand_pan();
                send_item(smp, pan, predict_lr(cur_law, smp, pan));
            end
        end

        i_in_valid     <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        waited = 0;
        while (lr_expect_q.size() != 0 && waited < 2000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (12) @(negedge i_clk);
        if (lr_expect_q.size() != 0) begin
            $error("%0d results never arrived", lr_expect_q.size());
            n_fail++;
        end

        $display("Sent %0d items under %0d law writes (all four laws, four idling modes),",
                 n_items, n_law_writes);
        $display("checked %0d left/right pairs, %0d mismatches.", n_results, n_fail);
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/splg_pkg.sv
rtl/splg_sine_lane.sv
rtl/splg_sqrt_lane.sv
rtl/stereo_pan_law_gain_unit.sv
tb/stereo_pan_law_gain_unit_tb.sv
